// ===== hw/rtl/ufd_pkg.sv =====
// Shared widths, request codes and default sizes for the union-find engine.
package ufd_pkg;

  localparam int unsigned DEF_MAX_ELEMENTS  = 1024;
  localparam int unsigned DEF_MAX_SEPARATES = 1024;

  localparam int unsigned REQ_W   = 2;
  localparam int unsigned ELEM_W  = 10;
  localparam int unsigned CFG_W   = 11;
  localparam int unsigned COUNT_W = 11;

  typedef enum logic [REQ_W-1:0] {
    REQ_INIT     = 2'd0,
    REQ_MERGE    = 2'd1,
    REQ_SEPARATE = 2'd2,
    REQ_COUNT    = 2'd3
  } req_e;

endpackage

// ===== hw/rtl/union_find_with_delete_unit.sv =====
// Disjoint-set engine with deletion through fresh virtual nodes.
// Separate, or a merge/separate naming an out-of-range element: result in the cycle
//   after start, busy stays low. Merge: walks and compresses each element's path, then links the roots.
// Init: one parent entry written per cycle over the whole table (Depth = 2*MaxElements+MaxSeparates).
// Count: clears the mark memory, then per element finds and compresses its root and marks it.
// One request at a time: a start is taken only while the engine is idle.
// Reset: asynchronous; clears control, element_count to MaxElements, fresh node to zero;
//   the parent memory holds garbage until an init request. Results cannot be stalled.
module union_find_with_delete_unit
  import ufd_pkg::*;
#(
  parameter int unsigned MaxElements  = DEF_MAX_ELEMENTS,
  parameter int unsigned MaxSeparates = DEF_MAX_SEPARATES
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [REQ_W-1:0]   req_type_i,
  input  logic [ELEM_W-1:0]  first_element_i,
  input  logic [ELEM_W-1:0]  second_element_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CFG_W-1:0]   cfg_data_i,
  output logic               done_o,
  output logic [COUNT_W-1:0] set_count_o,
  output logic               count_valid_o,
  output logic               table_full_o
);

  localparam int unsigned Depth = 2 * MaxElements + MaxSeparates;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned CW    = $clog2(Depth + 1);
  localparam int unsigned NW    = $clog2(MaxElements + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_INIT, S_CLR, S_FIND, S_WALK, S_COMP, S_MARK
  } state_e;

  typedef enum logic [1:0] {PH_FIRST, PH_SECOND, PH_COUNT} phase_e;

  state_e          state_q, state_d;
  phase_e          phase_q, phase_d;
  logic [NW-1:0]   n_q, n_d;
  logic [CW-1:0]   fresh_q, fresh_d;
  logic [CW-1:0]   idx_q, idx_d;
  logic [CW-1:0]   steps_q, steps_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [AW-1:0]   cur_q, cur_d;
  logic [AW-1:0]   start_q, start_d;
  logic [AW-1:0]   root_q, root_d;
  logic [AW-1:0]   r1_q, r1_d;
  logic [AW-1:0]   e2_q, e2_d;
  logic            done_d, valid_d, full_d;
  logic [COUNT_W-1:0] set_count_d;

  // parent memory and mark memory, both with registered reads
  logic [AW-1:0]   par_mem [Depth];
  logic [AW-1:0]   par_rd_q;
  logic            par_we;
  logic [AW-1:0]   par_wa, par_wd, par_ra;
  logic            mk_mem [Depth];
  logic            mk_rd_q;
  logic            mk_we, mk_wd;
  logic [AW-1:0]   mk_a;

  logic [AW-1:0]   up_node;
  logic            e1_ok, e2_ok, no_fresh, step_ok;
  logic [CW-1:0]   idx_inc;

  assign up_node  = (32'(par_rd_q) < Depth) ? par_rd_q : cur_q;
  assign e1_ok    = 32'(first_element_i) < 32'(n_q);
  assign e2_ok    = 32'(second_element_i) < 32'(n_q);
  assign no_fresh = (32'(fresh_q) >= 2 * 32'(n_q) + MaxSeparates) || (32'(fresh_q) >= Depth);
  assign step_ok  = 32'(steps_q) < Depth;
  assign idx_inc  = idx_q + CW'(1);

  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    fresh_d     = fresh_q;
    idx_d       = idx_q;
    steps_d     = steps_q;
    cnt_d       = cnt_q;
    cur_d       = cur_q;
    start_d     = start_q;
    root_d      = root_q;
    r1_d        = r1_q;
    e2_d        = e2_q;
    done_d      = 1'b0;
    valid_d     = 1'b0;
    full_d      = 1'b0;
    set_count_d = '0;
    par_we      = 1'b0;
    par_wa      = cur_q;
    par_wd      = root_q;
    par_ra      = cur_q;
    mk_we       = 1'b0;
    mk_wd       = 1'b0;
    mk_a        = root_q;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          unique case (req_e'(req_type_i))
            REQ_INIT: begin
              idx_d   = '0;
              state_d = S_INIT;
            end
            REQ_MERGE: begin
              if (e1_ok && e2_ok) begin
                start_d = AW'(first_element_i);
                e2_d    = AW'(second_element_i);
                phase_d = PH_FIRST;
                state_d = S_FIND;
              end else begin
                done_d = 1'b1;
              end
            end
            REQ_SEPARATE: begin
              if (e1_ok) begin
                if (no_fresh) begin
                  full_d = 1'b1;
                end else begin
                  par_we  = 1'b1;
                  par_wa  = AW'(first_element_i);
                  par_wd  = AW'(fresh_q);
                  fresh_d = fresh_q + CW'(1);
                end
              end
              done_d = 1'b1;
            end
            REQ_COUNT: begin
              idx_d   = '0;
              cnt_d   = '0;
              phase_d = PH_COUNT;
              state_d = S_CLR;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_INIT: begin
        par_we = 1'b1;
        par_wa = idx_q[AW-1:0];
        par_wd = (32'(idx_q) < 32'(n_q)) ? AW'(32'(idx_q) + 32'(n_q)) : idx_q[AW-1:0];
        if (32'(idx_q) == Depth - 1) begin
          fresh_d = CW'(2 * 32'(n_q));
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          idx_d = idx_inc;
        end
      end
      S_CLR: begin
        mk_we = 1'b1;
        mk_a  = idx_q[AW-1:0];
        if (32'(idx_q) == Depth - 1) begin
          idx_d   = '0;
          start_d = '0;
          state_d = S_FIND;
        end else begin
          idx_d = idx_inc;
        end
      end
      S_FIND: begin
        par_ra  = start_q;
        cur_d   = start_q;
        steps_d = '0;
        state_d = S_WALK;
      end
      S_WALK: begin
        if (step_ok && up_node != cur_q) begin
          cur_d   = up_node;
          steps_d = steps_q + CW'(1);
          par_ra  = up_node;
        end else begin
          // root found: rewalk from the start, pointing each node at it
          root_d  = cur_q;
          par_ra  = start_q;
          cur_d   = start_q;
          steps_d = '0;
          state_d = S_COMP;
        end
      end
      S_COMP: begin
        if (step_ok && cur_q != root_q && up_node != cur_q) begin
          par_we  = 1'b1;
          par_wa  = cur_q;
          par_wd  = root_q;
          cur_d   = up_node;
          steps_d = steps_q + CW'(1);
          par_ra  = up_node;
        end else begin
          unique case (phase_q)
            PH_FIRST: begin
              r1_d    = root_q;
              start_d = e2_q;
              phase_d = PH_SECOND;
              state_d = S_FIND;
            end
            PH_SECOND: begin
              if (r1_q != root_q) begin
                par_we = 1'b1;
                par_wa = r1_q;
                par_wd = root_q;
              end
              done_d  = 1'b1;
              state_d = S_IDLE;
            end
            default: begin
              mk_a    = root_q;
              state_d = S_MARK;
            end
          endcase
        end
      end
      S_MARK: begin
        if (!mk_rd_q) begin
          mk_we = 1'b1;
          mk_wd = 1'b1;
          cnt_d = cnt_q + CW'(1);
        end
        if (32'(idx_inc) == 32'(n_q)) begin
          done_d      = 1'b1;
          valid_d     = 1'b1;
          set_count_d = COUNT_W'(cnt_d);
          state_d     = S_IDLE;
        end else begin
          idx_d   = idx_inc;
          start_d = idx_inc[AW-1:0];
          state_d = S_FIND;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // clamp the written element count to 1..MaxElements
  always_comb begin
    n_d = n_q;
    if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_data_i == '0) begin
        n_d = NW'(1);
      end else if (32'(cfg_data_i) > MaxElements) begin
        n_d = NW'(MaxElements);
      end else begin
        n_d = NW'(cfg_data_i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      phase_q       <= PH_FIRST;
      n_q           <= NW'(MaxElements);
      fresh_q       <= '0;
      idx_q         <= '0;
      steps_q       <= '0;
      cnt_q         <= '0;
      done_o        <= 1'b0;
      count_valid_o <= 1'b0;
      table_full_o  <= 1'b0;
      set_count_o   <= '0;
    end else begin
      state_q       <= state_d;
      phase_q       <= phase_d;
      n_q           <= n_d;
      fresh_q       <= fresh_d;
      idx_q         <= idx_d;
      steps_q       <= steps_d;
      cnt_q         <= cnt_d;
      done_o        <= done_d;
      count_valid_o <= valid_d;
      table_full_o  <= full_d;
      set_count_o   <= set_count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    start_q <= start_d;
    root_q  <= root_d;
    r1_q    <= r1_d;
    e2_q    <= e2_d;
  end

  always_ff @(posedge clk_i) begin
    if (par_we) begin
      par_mem[par_wa] <= par_wd;
    end
    par_rd_q <= par_mem[par_ra];
  end

  always_ff @(posedge clk_i) begin
    if (mk_we) begin
      mk_mem[mk_a] <= mk_wd;
    end
    mk_rd_q <= mk_mem[mk_a];
  end

  a_count_not_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && count_valid_o |-> !table_full_o)
    else $error("count result flagged full");

  a_count_from_mark : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && count_valid_o |-> $past(state_q) == S_MARK)
    else $error("count result not issued from mark step");

  a_fresh_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(fresh_q) <= Depth)
    else $error("fresh node beyond table");

  a_walk_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK || state_q == S_COMP) |-> 32'(steps_q) <= Depth)
    else $error("walk step count beyond table depth");

endmodule

// ===== verif/union_find_with_delete_checker.sv =====
// Checker for the union-find engine: tracks requests and config, predicts each result, compares.
module union_find_with_delete_checker
  import ufd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  logic [REQ_W-1:0]   req_type_i,
  input  logic [ELEM_W-1:0]  first_element_i,
  input  logic [ELEM_W-1:0]  second_element_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [CFG_W-1:0]   cfg_data_i,
  input  logic               done_i,
  input  logic [COUNT_W-1:0] set_count_i,
  input  logic               count_valid_i,
  input  logic               table_full_i,
  output int                 fail_count_o,
  output int                 pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Depth = 2 * DEF_MAX_ELEMENTS + DEF_MAX_SEPARATES;

  typedef struct packed {
    logic [COUNT_W-1:0] set_count;
    logic               count_valid;
    logic               table_full;
  } uf_result_t;

  int unsigned  link [Depth];
  bit           seen [Depth];
  int unsigned  fresh_node;
  int unsigned  elem_cnt;
  uf_result_t   result_q [$];

  assign pending_o = result_q.size();

  function automatic int unsigned step_up(int unsigned node);
    return (link[node] < Depth) ? link[node] : node;
  endfunction

  // Walk to the root, then point every node on the path at it.
  function automatic int unsigned root_of(int unsigned node);
    int unsigned r;
    int unsigned a;
    int unsigned nxt;
    int unsigned steps;
    r = node;
    a = node;
    steps = 0;
    while (steps < Depth && step_up(r) != r) begin
      r = step_up(r);
      steps++;
    end
    steps = 0;
    while (steps < Depth && a != r && step_up(a) != a) begin
      nxt = step_up(a);
      link[a] = r;
      a = nxt;
      steps++;
    end
    return r;
  endfunction

  function automatic uf_result_t apply_request(req_e req, int unsigned e1, int unsigned e2);
    uf_result_t res;
    int unsigned r1;
    int unsigned r2;
    res = '0;
    case (req)
      REQ_INIT: begin
        for (int unsigned i = 0; i < Depth; i++) begin
          link[i] = (i < elem_cnt) ? i + elem_cnt : i;
          seen[i] = 1'b0;
        end
        fresh_node = 2 * elem_cnt;
      end
      REQ_MERGE: begin
        if (e1 < elem_cnt && e2 < elem_cnt) begin
          r1 = root_of(e1);
          r2 = root_of(e2);
          if (r1 != r2) link[r1] = r2;
        end
      end
      REQ_SEPARATE: begin
        if (e1 < elem_cnt) begin
          if (fresh_node >= 2 * elem_cnt + DEF_MAX_SEPARATES || fresh_node >= Depth) begin
            res.table_full = 1'b1;
          end else begin
            link[e1] = fresh_node;
            fresh_node++;
          end
        end
      end
      default: begin
        for (int unsigned i = 0; i < Depth; i++) seen[i] = 1'b0;
        for (int unsigned i = 0; i < elem_cnt; i++) begin
          r1 = root_of(i);
          if (!seen[r1]) begin
            seen[r1] = 1'b1;
            res.set_count++;
          end
        end
        res.count_valid = 1'b1;
      end
    endcase
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    uf_result_t want;
    if (!rst_ni) begin
      fresh_node   = 0;
      elem_cnt     = DEF_MAX_ELEMENTS;
      fail_count_o = 0;
      result_q.delete();
      for (int unsigned i = 0; i < Depth; i++) begin
        link[i] = 0;
        seen[i] = 1'b0;
      end
    end else begin
      if (done_i) begin
        if (result_q.size() == 0) begin
          $display("%0t: result word with nothing expected: count %0d valid %0b full %0b",
                   $time, set_count_i, count_valid_i, table_full_i);
          fail_count_o++;
        end else begin
          want = result_q.pop_front();
          if (want.set_count !== set_count_i) begin
            $display("%0t: set_count expected %0d actual %0d", $time, want.set_count,
                     set_count_i);
            fail_count_o++;
          end
          if (want.count_valid !== count_valid_i) begin
            $display("%0t: count_valid expected %0b actual %0b", $time, want.count_valid,
                     count_valid_i);
            fail_count_o++;
          end
          if (want.table_full !== table_full_i) begin
            $display("%0t: table_full expected %0b actual %0b", $time, want.table_full,
                     table_full_i);
            fail_count_o++;
          end
        end
      end
      if (start_i && !busy_i) begin
        result_q.push_back(apply_request(req_e'(req_type_i), first_element_i,
                                         second_element_i));
      end
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_data_i == 0) elem_cnt = 1;
        else if (cfg_data_i > DEF_MAX_ELEMENTS) elem_cnt = DEF_MAX_ELEMENTS;
        else elem_cnt = cfg_data_i;
      end
    end
  end

endmodule

// ===== verif/union_find_with_delete_unit_tb.sv =====
// Testbench top for the union-find engine: drives requests and config, gives the verdict.
module union_find_with_delete_unit_tb;
  import ufd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // A count over a table left cyclic can walk the full depth twice for every element.
  localparam int StallLimit = 25000000;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic [REQ_W-1:0]   req_type_i;
  logic [ELEM_W-1:0]  first_element_i;
  logic [ELEM_W-1:0]  second_element_i;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CFG_W-1:0]   cfg_data_i;
  logic               done_o;
  logic [COUNT_W-1:0] set_count_o;
  logic               count_valid_o;
  logic               table_full_o;
  int                 fail_count;
  int                 pending;
  int                 stall_cycles;
  int                 idle_pct;
  int unsigned        cur_n;

  union_find_with_delete_unit DUT (
    .clk_i, .rst_ni, .start, .busy, .req_type_i, .first_element_i, .second_element_i,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i, .done_o, .set_count_o, .count_valid_o,
    .table_full_o
  );

  union_find_with_delete_checker u_checker (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .req_type_i, .first_element_i,
    .second_element_i, .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_data_i,
    .done_i(done_o), .set_count_i(set_count_o), .count_valid_i(count_valid_o),
    .table_full_i(table_full_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Abort when nothing moves for too long.
  always @(posedge clk_i) begin
    if ((start && !busy) || (cfg_valid_i && cfg_ready_o) || done_o) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Leaves start high so a back-to-back word needs no second assignment.
  task automatic send_req(req_e req, logic [ELEM_W-1:0] e1, logic [ELEM_W-1:0] e2);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start            <= 1'b1;
    req_type_i       <= req;
    first_element_i  <= e1;
    second_element_i <= e2;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk_i); while (pending != 0 || busy);
  endtask

  task automatic write_size(logic [CFG_W-1:0] value);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (value == 0) cur_n = 1;
    else if (value > DEF_MAX_ELEMENTS) cur_n = DEF_MAX_ELEMENTS;
    else cur_n = value;
  endtask

  function automatic logic [ELEM_W-1:0] pick_elem();
    if ($urandom_range(99) < 90) return ELEM_W'($urandom_range(cur_n - 1));
    return ELEM_W'($urandom);
  endfunction

  task automatic random_phase(int items);
    int done_items;
    int run_len;
    int roll;
    done_items = 0;
    while (done_items < items) begin
      roll = $urandom_range(99);
      if (roll < 5) write_size(0);
      else if (roll < 10) write_size(2047);
      else if (roll < 14) write_size(CFG_W'($urandom_range(2047, 1025)));
      else if (roll < 22) write_size(CFG_W'(DEF_MAX_ELEMENTS));
      else if (roll < 30) write_size(1);
      else write_size(CFG_W'($urandom_range(48, 2)));
      // Mostly re-init; sometimes keep the old table under the new size.
      if ($urandom_range(99) < 85) begin
        send_req(REQ_INIT, pick_elem(), pick_elem());
        done_items++;
      end
      run_len = (cur_n > 100) ? $urandom_range(30, 8) : $urandom_range(60, 20);
      repeat (run_len) begin
        roll = $urandom_range(99);
        if (roll < 55) send_req(REQ_MERGE, pick_elem(), pick_elem());
        else if (roll < 83) send_req(REQ_SEPARATE, pick_elem(), pick_elem());
        else if (roll < 97) send_req(REQ_COUNT, pick_elem(), pick_elem());
        else send_req(REQ_INIT, pick_elem(), pick_elem());
        done_items++;
      end
    end
  endtask

  initial begin
    rst_ni           = 1'b0;
    start            = 1'b0;
    req_type_i       = REQ_INIT;
    first_element_i  = '0;
    second_element_i = '0;
    cfg_valid_i      = 1'b0;
    cfg_data_i       = '0;
    stall_cycles     = 0;
    idle_pct         = 0;
    cur_n            = DEF_MAX_ELEMENTS;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_size(4);
    send_req(REQ_INIT, 0, 0);
    send_req(REQ_COUNT, 0, 0);
    send_req(REQ_MERGE, 0, 1);
    send_req(REQ_MERGE, 2, 3);
    send_req(REQ_MERGE, 1, 3);
    send_req(REQ_COUNT, 0, 0);
    send_req(REQ_SEPARATE, 1, 0);
    send_req(REQ_MERGE, 3, 3);
    send_req(REQ_COUNT, 0, 0);
    // Out-of-range elements are dropped.
    send_req(REQ_MERGE, 4, 0);
    send_req(REQ_MERGE, 0, 1023);
    send_req(REQ_SEPARATE, 1023, 1023);
    send_req(REQ_COUNT, 1023, 1023);
    write_size(0);
    send_req(REQ_INIT, 0, 0);
    send_req(REQ_SEPARATE, 0, 0);
    send_req(REQ_COUNT, 0, 0);
    write_size(2047);
    send_req(REQ_INIT, 0, 0);
    send_req(REQ_MERGE, 1023, 0);
    send_req(REQ_COUNT, 0, 0);
    // Shrink without init: fresh counter is past the new limit, so separate is refused.
    write_size(1);
    send_req(REQ_SEPARATE, 0, 0);
    send_req(REQ_MERGE, 0, 0);
    send_req(REQ_COUNT, 0, 0);

    idle_pct = 36;
    random_phase(600);
    idle_pct = 57;
    random_phase(600);
    idle_pct = 0;
    random_phase(600);

    drain();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
